// ----- src/pcl_pkg.sv -----
// ---------------------------------------------------------------------------
// pcl_pkg: shared types and constants
// Opcodes, status codes, widths and the command struct that the list control
// broadcasts to every character cell.
// ---------------------------------------------------------------------------
package pcl_pkg;

  localparam int OPCODE_W = 2;
  localparam int POS_W    = 8;
  localparam int CHAR_W   = 8;
  localparam int STATUS_W = 2;
  localparam int LENGTH_W = 5;

  // positions and counts are compared at one bit above the position field,
  // enough to hold a count of up to 256
  localparam int CMP_W = POS_W + 1;

  localparam int DEFAULT_CAPACITY = 16;

  localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PAST_END = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic              shift_ins;  // open a gap at pos and write ch there
    logic              shift_del;  // close the gap at pos
    logic [CMP_W-1:0]  pos;
    logic [CHAR_W-1:0] ch;
  } pcl_cmd_t;

endpackage

// ----- src/pcl_cell.sv -----
// ---------------------------------------------------------------------------
// pcl_cell: one character cell of the list
// Holds one character, compares its own index with the broadcast position
// and takes its neighbour's character on an insert or delete shift.
// ---------------------------------------------------------------------------
module pcl_cell
  import pcl_pkg::*;
#(
  parameter logic [CMP_W-1:0] INDEX = '0
) (
  input  logic              clk,
  input  pcl_cmd_t          cmd,
  input  logic [CHAR_W-1:0] prev_char,
  input  logic [CHAR_W-1:0] next_char,
  output logic [CHAR_W-1:0] char_q,
  output logic [CHAR_W-1:0] pick
);

  logic [CHAR_W-1:0] char_r;
  logic [CHAR_W-1:0] char_nxt;
  logic              hit;
  logic              above;

  assign hit   = (INDEX == cmd.pos);
  assign above = (INDEX > cmd.pos);

  always_comb begin
    char_nxt = char_r;
    if (cmd.shift_ins) begin
      if (hit) begin
        char_nxt = cmd.ch;
      end else if (above) begin
        char_nxt = prev_char;
      end
    end else if (cmd.shift_del) begin
      if (hit || above) begin
        char_nxt = next_char;
      end
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  assign char_q = char_r;
  assign pick   = hit ? char_r : '0;

endmodule

// ----- src/positional_char_list_top.sv -----
// ---------------------------------------------------------------------------
// positional_char_list_top: bounded list of characters with positional access
// Insert, delete or read a character at a position in a chain of cells.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries opcode, position and char_in.
//   Result channel (out_valid/out_ready) returns one result per item: the
//   removed or read character, a status, the length and an empty flag.
//   An item is taken into registers and executed once the output register
//   is free or being drained: every cell compares its index with the
//   position and shifts locally, and the result is written to the output
//   register. The block takes no new item until the one before has executed.
//   in_ready is low while an item is executing. If the receiver stalls with
//   a result still held, the executing item waits until the output register
//   frees, so no result is lost or overwritten.
//   Reset (rst_n low, synchronous) empties the list and drops any held
//   result; cell contents are left as they are and are never read before
//   they are written.
// ---------------------------------------------------------------------------
module positional_char_list_top
  import pcl_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPCODE_W-1:0] in_opcode,
  input  logic [POS_W-1:0]    in_position,
  input  logic [CHAR_W-1:0]   in_char_in,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHAR_W-1:0]   out_char_out,
  output logic [STATUS_W-1:0] out_status,
  output logic [LENGTH_W-1:0] out_length,
  output logic                out_is_empty_flag
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CMP_W-1:0] CAP_EXT = CMP_W'(CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t                state_r;
  logic [CNT_W-1:0]      count_r;
  logic [OPCODE_W-1:0]   op_r;
  logic [POS_W-1:0]      pos_r;
  logic [CHAR_W-1:0]     ch_r;
  logic                  out_valid_r;
  logic [CHAR_W-1:0]     char_out_r;
  logic [STATUS_W-1:0]   status_r;
  logic [LENGTH_W-1:0]   length_r;
  logic                  empty_r;

  logic                  fire;
  logic [CMP_W-1:0]      count_ext;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      count_nxt_ext;
  logic [CNT_W-1:0]      count_nxt;
  logic [STATUS_W-1:0]   status_nxt;
  logic [CHAR_W-1:0]     char_out_nxt;
  logic                  past_end;
  logic                  full;
  logic [CHAR_W-1:0]     picked;
  pcl_cmd_t              cmd;

  logic [CHAR_W-1:0]     cell_char [CAPACITY];
  logic [CHAR_W-1:0]     cell_pick [CAPACITY];

  assign in_ready  = (state_r == S_IDLE);
  // execute once the output register is free or being drained
  assign fire      = (state_r == S_EXEC) && (!out_valid_r || out_ready);
  assign count_ext = CMP_W'(count_r);
  assign pos_ext   = CMP_W'(pos_r);
  assign full      = (count_ext == CAP_EXT);
  assign past_end  = (pos_ext >= count_ext);

  always_comb begin
    picked = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      picked = picked | cell_pick[i];
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.ch        = ch_r;
    cmd.pos       = pos_ext;
    count_nxt_ext = count_ext;
    status_nxt    = ST_OK;
    char_out_nxt  = '0;
    case (op_r)
      OP_INSERT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          // append when the position lies past the end
          if (past_end) begin
            cmd.pos = count_ext;
          end
          cmd.shift_ins = fire;
          count_nxt_ext = count_ext + CMP_W'(1);
        end
      end
      OP_DELETE: begin
        if (past_end) begin
          status_nxt = ST_PAST_END;
        end else begin
          cmd.shift_del = fire;
          char_out_nxt  = picked;
          count_nxt_ext = count_ext - CMP_W'(1);
        end
      end
      OP_READ: begin
        if (past_end) begin
          status_nxt = ST_PAST_END;
        end else begin
          char_out_nxt = picked;
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  assign count_nxt = count_nxt_ext[CNT_W-1:0];

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    pcl_cell #(
      .INDEX (CMP_W'(g))
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .prev_char (cell_char[(g == 0) ? 0 : g - 1]),
      .next_char (cell_char[(g == CAPACITY - 1) ? g : g + 1]),
      .char_q    (cell_char[g]),
      .pick      (cell_pick[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (fire) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (in_valid && in_ready) begin
      op_r  <= in_opcode;
      pos_r <= in_position;
      ch_r  <= in_char_in;
    end
    if (fire) begin
      char_out_r <= char_out_nxt;
      status_r   <= status_nxt;
      length_r   <= count_nxt_ext[LENGTH_W-1:0];
      empty_r    <= (count_nxt_ext == '0);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_char_out      = char_out_r;
  assign out_status        = status_r;
  assign out_length        = length_r;
  assign out_is_empty_flag = empty_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= CAP_EXT)
    else $error("held count exceeds capacity");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is executing");

  a_fail_no_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> (out_char_out == '0))
    else $error("character reported on a failed operation");

  a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    fire && (op_r == OP_INSERT) && full |=> (count_r == $past(count_r)))
    else $error("insert into a full list changed the count");
`endif

endmodule
